// ----- rtl/pcent_pkg.sv -----
// Shared constants, codes and types of the polygon centroid block.
package pcent_pkg;

   localparam int MaxVertices = 256;
   localparam int CountWidth  = $clog2(MaxVertices + 2);

   localparam int CoordWidth  = 16;
   localparam int SumWidth    = CoordWidth + 1;
   localparam int EdgeWidth   = 2 * CoordWidth + 1;
   localparam int ProdWidth   = SumWidth + EdgeWidth;
   localparam int CrossWidth  = 43;
   localparam int MomentWidth = 60;
   localparam int DenWidth    = CrossWidth + 1;
   localparam int FracBits    = 8;
   localparam int IntBits     = 16;
   localparam int CentWidth   = IntBits + FracBits;
   localparam int StatusWidth = 2;
   localparam int StepWidth   = $clog2(CentWidth);

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_AREA = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A0,
      ST_MUL_A1,
      ST_CROSS,
      ST_MOM_X,
      ST_MOM_Y,
      ST_MOM_ACC,
      ST_CHECK,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_DIV_DONE,
      ST_RESULT
   } state_type;

endpackage

// ----- rtl/pcent_req_if.sv -----
// Vertex channel: valid/ready handshake with one vertex per word.
interface pcent_req_if import pcent_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [CoordWidth-1:0] vertex_x;
   logic signed [CoordWidth-1:0] vertex_y;
   logic                         last_vertex;

   modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
   modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

// ----- rtl/pcent_rsp_if.sv -----
// Result channel: valid/ready handshake with one centroid per word.
interface pcent_rsp_if import pcent_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [CentWidth-1:0]  centroid_x;
   logic signed [CentWidth-1:0]  centroid_y;
   logic [StatusWidth-1:0]       status;

   modport source (output valid, centroid_x, centroid_y, status, input ready);
   modport sink   (input valid, centroid_x, centroid_y, status, output ready);
endinterface

// ----- rtl/polygon_centroid.sv -----
// Shoelace polygon centroid: one shared multiplier for edges, one shared divider for axes.
// A vertex that is not the last passes through 6 sequencer steps (4 of them on the
// multiplier) before ready rises again; the first vertex of a polygon is only stored.
// The last vertex adds the closing edge, a check and two divisions, each of 24 restoring
// steps (skipped if the axis saturates); the result is then held valid until taken. A
// vertex beyond the limit is dropped, and a last one beyond it gives an overflow result.
// Synchronous active-high reset clears the sums, vertex count and pending result.
module polygon_centroid import pcent_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   pcent_req_if.sink    req_chan,
   pcent_rsp_if.source  rsp_chan
);

   state_type state_ff, state_in;

   logic signed [CoordWidth-1:0]  first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [CoordWidth-1:0]  prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [CoordWidth-1:0]  ex0_ff, ex0_in, ey0_ff, ey0_in;
   logic signed [CoordWidth-1:0]  ex1_ff, ex1_in, ey1_ff, ey1_in;
   logic [CountWidth-1:0]         count_ff, count_in;
   logic                          last_ff, last_in;
   logic                          closing_ff, closing_in;

   logic signed [ProdWidth-1:0]   prod_ff, prod_in;
   logic signed [EdgeWidth-1:0]   edge_ff, edge_in;
   logic signed [CrossWidth-1:0]  cross_ff, cross_in;
   logic signed [MomentWidth-1:0] mx_ff, mx_in, my_ff, my_in;

   logic [DenWidth-1:0]           den_ff, den_in;
   logic                          cross_neg_ff, cross_neg_in;
   logic                          sel_ff, sel_in;
   logic                          neg_ff, neg_in;
   logic                          sat_ff, sat_in;
   logic [DenWidth-1:0]           rem_ff, rem_in;
   logic [CentWidth-1:0]          low_ff, low_in;
   logic [CentWidth-1:0]          quot_ff, quot_in;
   logic [StepWidth-1:0]          step_ff, step_in;

   logic signed [CentWidth-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic [StatusWidth-1:0]        status_ff, status_in;

   logic signed [SumWidth-1:0]    opa;
   logic signed [EdgeWidth-1:0]   opb;
   logic signed [ProdWidth-1:0]   product;

   logic [CrossWidth-1:0]         cross_mag;
   logic signed [MomentWidth-1:0] num;
   logic [MomentWidth-1:0]        num_mag;
   logic [DenWidth+1:0]           trial;
   logic [CentWidth:0]            mag;
   logic [CentWidth-1:0]          clamped;
   logic                          accept;

   assign product = opa * opb;

   assign accept             = req_chan.valid && req_chan.ready;
   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = (state_ff == ST_RESULT);
   assign rsp_chan.centroid_x = cx_ff;
   assign rsp_chan.centroid_y = cy_ff;
   assign rsp_chan.status    = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         count_ff     <= '0;
         last_ff      <= 1'b0;
         closing_ff   <= 1'b0;
         cross_ff     <= '0;
         mx_ff        <= '0;
         my_ff        <= '0;
         sel_ff       <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         first_x_ff   <= first_x_in;
         first_y_ff   <= first_y_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         closing_ff   <= closing_in;
         cross_ff     <= cross_in;
         mx_ff        <= mx_in;
         my_ff        <= my_in;
         sel_ff       <= sel_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      ex0_ff       <= ex0_in;
      ey0_ff       <= ey0_in;
      ex1_ff       <= ex1_in;
      ey1_ff       <= ey1_in;
      prod_ff      <= prod_in;
      edge_ff      <= edge_in;
      den_ff       <= den_in;
      cross_neg_ff <= cross_neg_in;
      neg_ff       <= neg_in;
      sat_ff       <= sat_in;
      rem_ff       <= rem_in;
      low_ff       <= low_in;
      quot_ff      <= quot_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      status_ff    <= status_in;
   end

   always_comb begin
      state_in     = state_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      ex0_in       = ex0_ff;
      ey0_in       = ey0_ff;
      ex1_in       = ex1_ff;
      ey1_in       = ey1_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      closing_in   = closing_ff;
      prod_in      = prod_ff;
      edge_in      = edge_ff;
      cross_in     = cross_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      den_in       = den_ff;
      cross_neg_in = cross_neg_ff;
      sel_in       = sel_ff;
      neg_in       = neg_ff;
      sat_in       = sat_ff;
      rem_in       = rem_ff;
      low_in       = low_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      status_in    = status_ff;

      opa       = SumWidth'(ex0_ff);
      opb       = EdgeWidth'(ey1_ff);
      cross_mag = cross_ff[CrossWidth-1] ? CrossWidth'(-cross_ff) : CrossWidth'(cross_ff);
      num       = sel_ff ? my_ff : mx_ff;
      num_mag   = num[MomentWidth-1] ? MomentWidth'(-num) : MomentWidth'(num);
      trial     = {1'b0, rem_ff, low_ff[CentWidth-1]} - {2'b00, den_ff};
      mag       = sat_ff ? (CentWidth+1)'(1) << CentWidth : {1'b0, quot_ff};
      if (neg_ff) begin
         clamped = (mag > (CentWidth+1)'(1) << (CentWidth-1))
                   ? CentWidth'(1) << (CentWidth-1) : CentWidth'(-mag[CentWidth-1:0]);
      end else begin
         clamped = (mag > ((CentWidth+1)'(1) << (CentWidth-1)) - 1'b1)
                   ? (CentWidth'(1) << (CentWidth-1)) - 1'b1 : mag[CentWidth-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in    = req_chan.last_vertex;
               closing_in = 1'b0;
               if (count_ff >= CountWidth'(MaxVertices)) begin
                  // drop the word; only the flag matters now
                  count_in = CountWidth'(MaxVertices + 1);
                  if (req_chan.last_vertex) begin
                     cx_in     = '0;
                     cy_in     = '0;
                     status_in = STATUS_OVERFLOW;
                     state_in  = ST_RESULT;
                  end
               end else begin
                  count_in  = count_ff + 1'b1;
                  prev_x_in = req_chan.vertex_x;
                  prev_y_in = req_chan.vertex_y;
                  ex1_in    = req_chan.vertex_x;
                  ey1_in    = req_chan.vertex_y;
                  if (count_ff == '0) begin
                     first_x_in = req_chan.vertex_x;
                     first_y_in = req_chan.vertex_y;
                     if (req_chan.last_vertex) begin
                        // single vertex: closing edge onto itself
                        ex0_in     = req_chan.vertex_x;
                        ey0_in     = req_chan.vertex_y;
                        closing_in = 1'b1;
                        state_in   = ST_MUL_A0;
                     end
                  end else begin
                     ex0_in   = prev_x_ff;
                     ey0_in   = prev_y_ff;
                     state_in = ST_MUL_A0;
                  end
               end
            end
         end
         ST_MUL_A0: begin
            opa      = SumWidth'(ex0_ff);
            opb      = EdgeWidth'(ey1_ff);
            prod_in  = product;
            state_in = ST_MUL_A1;
         end
         ST_MUL_A1: begin
            opa      = SumWidth'(ex1_ff);
            opb      = EdgeWidth'(ey0_ff);
            prod_in  = product;
            edge_in  = prod_ff[EdgeWidth-1:0];
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            edge_in  = edge_ff - prod_ff[EdgeWidth-1:0];
            state_in = ST_MOM_X;
         end
         ST_MOM_X: begin
            opa      = SumWidth'(ex0_ff) + SumWidth'(ex1_ff);
            opb      = edge_ff;
            prod_in  = product;
            cross_in = cross_ff + CrossWidth'(edge_ff);
            state_in = ST_MOM_Y;
         end
         ST_MOM_Y: begin
            opa      = SumWidth'(ey0_ff) + SumWidth'(ey1_ff);
            opb      = edge_ff;
            prod_in  = product;
            mx_in    = mx_ff + MomentWidth'(prod_ff);
            state_in = ST_MOM_ACC;
         end
         ST_MOM_ACC: begin
            my_in = my_ff + MomentWidth'(prod_ff);
            if (closing_ff) begin
               state_in = ST_CHECK;
            end else if (last_ff) begin
               // close the polygon back to the first vertex
               ex0_in     = prev_x_ff;
               ey0_in     = prev_y_ff;
               ex1_in     = first_x_ff;
               ey1_in     = first_y_ff;
               closing_in = 1'b1;
               state_in   = ST_MUL_A0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (cross_ff == '0) begin
               cx_in     = '0;
               cy_in     = '0;
               status_in = STATUS_ZERO_AREA;
               state_in  = ST_RESULT;
            end else begin
               den_in       = {cross_mag, 1'b0} + DenWidth'(cross_mag);
               cross_neg_in = cross_ff[CrossWidth-1];
               sel_in       = 1'b0;
               state_in     = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            neg_in  = num[MomentWidth-1] ^ cross_neg_ff;
            sat_in  = num_mag >= {den_ff, IntBits'(0)};
            rem_in  = num_mag[MomentWidth-1:IntBits];
            low_in  = {num_mag[IntBits-1:0], FracBits'(0)};
            quot_in = '0;
            step_in = '0;
            state_in = (num_mag >= {den_ff, IntBits'(0)}) ? ST_DIV_DONE : ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            // restoring step: one quotient bit per cycle
            if (!trial[DenWidth+1]) begin
               rem_in  = trial[DenWidth-1:0];
               quot_in = {quot_ff[CentWidth-2:0], 1'b1};
            end else begin
               rem_in  = {rem_ff[DenWidth-2:0], low_ff[CentWidth-1]};
               quot_in = {quot_ff[CentWidth-2:0], 1'b0};
            end
            low_in  = {low_ff[CentWidth-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == StepWidth'(CentWidth - 1)) begin
               state_in = ST_DIV_DONE;
            end
         end
         ST_DIV_DONE: begin
            if (sel_ff) begin
               cy_in     = clamped;
               status_in = STATUS_OK;
               state_in  = ST_RESULT;
            end else begin
               cx_in    = clamped;
               sel_in   = 1'b1;
               state_in = ST_DIV_LOAD;
            end
         end
         ST_RESULT: begin
            if (rsp_chan.ready) begin
               first_x_in = '0;
               first_y_in = '0;
               prev_x_in  = '0;
               prev_y_in  = '0;
               count_in   = '0;
               cross_in   = '0;
               mx_in      = '0;
               my_in      = '0;
               last_in    = 1'b0;
               closing_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for polygon_centroid against a shoelace predictor.
`timescale 1ns / 100ps
module tb_top import pcent_pkg::*; ();

   localparam int CycleLimit     = 1_000_000;
   localparam int SettleCycles   = 150;
   localparam int HoldoffCycles  = 400;
   localparam int TargetVertices = 2000;
   localparam int FullSpan       = 1 << (CoordWidth - 1);

   typedef struct {
      logic signed [CoordWidth-1:0] x;
      logic signed [CoordWidth-1:0] y;
      logic                         last;
      logic                         drain;
   } vertex_word_type;

   typedef struct {
      logic signed [CentWidth-1:0] cx;
      logic signed [CentWidth-1:0] cy;
      status_type                  status;
   } centroid_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pcent_req_if req_bus ();
   pcent_rsp_if rsp_bus ();

   polygon_centroid dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   vertex_word_type   vertex_backlog[$];
   centroid_word_type pending_centroids[$];

   // predictor state for the polygon being built
   longint first_x = 0, first_y = 0, prev_x = 0, prev_y = 0;
   longint cross_acc = 0, moment_x_acc = 0, moment_y_acc = 0;
   int     vertex_total = 0;

   logic       req_taken = 1'b0;
   int         vertices_taken = 0;
   int         mismatch_count = 0;
   int         cycle_count = 0;
   int         gap_left = 0;
   int         burst_left = 0;
   int         holdoff_left = 0;
   int         holdoffs_done = 0;
   int         holdoff_mark = 300;
   logic [15:0] pattern_bits = '1;
   logic [3:0]  pattern_pos = '0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic void add_edge(longint x0, longint y0, longint x1, longint y1);
      longint twice_area;
      twice_area = x0 * y1 - x1 * y0;
      cross_acc    += twice_area;
      moment_x_acc += (x0 + x1) * twice_area;
      moment_y_acc += (y0 + y1) * twice_area;
   endfunction

   // Q16.8 quotient, truncated toward zero and clamped to 24 bits
   function automatic logic [CentWidth-1:0] to_q16_8(longint num, longint den);
      logic                  negative;
      longint unsigned       mag_num, mag_den, whole, rest, mag;
      negative = (num < 0) != (den < 0);
      mag_num  = (num < 0) ? -num : num;
      mag_den  = (den < 0) ? -den : den;
      whole    = mag_num / mag_den;
      rest     = mag_num % mag_den;
      if (whole >= (64'd1 << IntBits)) begin
         mag = 64'd1 << CentWidth;
      end else begin
         mag = (whole << FracBits) + (rest << FracBits) / mag_den;
      end
      if (negative) begin
         if (mag > (64'd1 << (CentWidth - 1))) begin
            mag = 64'd1 << (CentWidth - 1);
         end
         mag = -mag;
      end else if (mag > (64'd1 << (CentWidth - 1)) - 1) begin
         mag = (64'd1 << (CentWidth - 1)) - 1;
      end
      return mag[CentWidth-1:0];
   endfunction

   function automatic void accumulate_vertex(logic signed [CoordWidth-1:0] vx,
                                             logic signed [CoordWidth-1:0] vy,
                                             logic last);
      centroid_word_type outcome;
      if (vertex_total >= MaxVertices) begin
         // drop vertices past the limit
         vertex_total = MaxVertices + 1;
      end else begin
         if (vertex_total == 0) begin
            first_x = vx;
            first_y = vy;
         end else begin
            add_edge(prev_x, prev_y, vx, vy);
         end
         prev_x = vx;
         prev_y = vy;
         vertex_total++;
      end
      if (last) begin
         outcome.cx = '0;
         outcome.cy = '0;
         if (vertex_total > MaxVertices) begin
            outcome.status = STATUS_OVERFLOW;
         end else begin
            add_edge(prev_x, prev_y, first_x, first_y);
            if (cross_acc == 0) begin
               outcome.status = STATUS_ZERO_AREA;
            end else begin
               outcome.cx     = to_q16_8(moment_x_acc, 3 * cross_acc);
               outcome.cy     = to_q16_8(moment_y_acc, 3 * cross_acc);
               outcome.status = STATUS_OK;
            end
         end
         pending_centroids.push_back(outcome);
         first_x = 0;
         first_y = 0;
         prev_x = 0;
         prev_y = 0;
         cross_acc = 0;
         moment_x_acc = 0;
         moment_y_acc = 0;
         vertex_total = 0;
      end
   endfunction

   function automatic void push_vertex(int x, int y, logic last, logic drain);
      vertex_word_type word;
      word.x     = CoordWidth'(x);
      word.y     = CoordWidth'(y);
      word.last  = last;
      word.drain = drain;
      vertex_backlog.push_back(word);
   endfunction

   function automatic void queue_polygon(int count, int span, logic drain);
      int x, y;
      for (int i = 0; i < count; i++) begin
         if (span >= FullSpan) begin
            x = $urandom;
            y = $urandom;
         end else begin
            x = int'($urandom_range(2 * span, 0)) - span;
            y = int'($urandom_range(2 * span, 0)) - span;
         end
         push_vertex(x, y, i == count - 1, drain && i == 0);
      end
   endfunction

   // sender: bursts of random length separated by random gaps
   always @(negedge clock) begin : drive_vertices
      vertex_word_type word;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left      <= gap_left - 1;
            req_bus.valid <= 1'b0;
         end else if (vertex_backlog.size() != 0 &&
                      !(vertex_backlog[0].drain && pending_centroids.size() != 0)) begin
            word = vertex_backlog.pop_front();
            req_bus.vertex_x    <= word.x;
            req_bus.vertex_y    <= word.y;
            req_bus.last_vertex <= word.last;
            req_bus.valid       <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(40, 1);
               gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver: a fresh 16-bit stall pattern each lap, sometimes without stalls
   always @(negedge clock) begin : pace_results
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (pattern_pos == 0) begin
            pattern_bits = ($urandom_range(3, 0) == 0) ? 16'hFFFF : 16'($urandom);
         end
         rsp_bus.ready <= (holdoff_left == 0) && pattern_bits[pattern_pos];
         pattern_pos = pattern_pos + 1'b1;
      end
   end

   // long receiver hold-off so the block backs up onto its input
   always @(negedge clock) begin : hold_results
      if (!reset) begin
         if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
         end else if (holdoffs_done < 2 && vertices_taken >= holdoff_mark) begin
            holdoff_left  <= HoldoffCycles;
            holdoffs_done <= holdoffs_done + 1;
            holdoff_mark  <= holdoff_mark + 1000;
         end
      end
   end

   always @(posedge clock) begin : watch_channels
      centroid_word_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            accumulate_vertex(req_bus.vertex_x, req_bus.vertex_y, req_bus.last_vertex);
            vertices_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_centroids.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected centroid word: x=%0d y=%0d status=%0d",
                           rsp_bus.centroid_x, rsp_bus.centroid_y, rsp_bus.status);
               end
            end else begin
               want = pending_centroids.pop_front();
               if (rsp_bus.centroid_x !== want.cx || rsp_bus.centroid_y !== want.cy ||
                   rsp_bus.status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("centroid mismatch: expected %0d,%0d st %0d, got %0d,%0d st %0d",
                              want.cx, want.cy, want.status,
                              rsp_bus.centroid_x, rsp_bus.centroid_y, rsp_bus.status);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin : run_test
      logic drain;
      int   pick;
      logic long_done;
      long_done = 1'b0;
      req_bus.valid       = 1'b0;
      req_bus.vertex_x    = '0;
      req_bus.vertex_y    = '0;
      req_bus.last_vertex = 1'b0;
      rsp_bus.ready       = 1'b0;

      // lone vertex and a pair: both close with no area
      push_vertex(32767, -32768, 1, 0);
      push_vertex(-32768, 32767, 0, 0);
      push_vertex(32767, -32768, 1, 0);
      // triangle on the coordinate extremes
      push_vertex(-32768, -32768, 0, 0);
      push_vertex(32767, -32768, 0, 0);
      push_vertex(-32768, 32767, 1, 0);
      // collinear points
      push_vertex(-5, -7, 0, 0);
      push_vertex(1, 2, 0, 0);
      push_vertex(7, 11, 1, 0);
      // two triangles of opposite winding, net area +1/2: clamps high
      push_vertex(0, 0, 0, 0);
      push_vertex(20000, 0, 0, 0);
      push_vertex(0, 20000, 0, 0);
      push_vertex(0, 0, 0, 0);
      push_vertex(-32768, -32768, 0, 0);
      push_vertex(-32768, -12769, 0, 0);
      push_vertex(-12767, -32768, 0, 0);
      push_vertex(-32768, -32768, 1, 0);
      // same shape with net area -1/2: clamps low
      push_vertex(0, 0, 0, 0);
      push_vertex(19999, 0, 0, 0);
      push_vertex(0, 20001, 0, 0);
      push_vertex(0, 0, 0, 0);
      push_vertex(-32768, -32768, 0, 0);
      push_vertex(-32768, -12768, 0, 0);
      push_vertex(-12768, -32768, 0, 0);
      push_vertex(-32768, -32768, 1, 0);

      // hold this one back until every centroid so far has come out
      queue_polygon(5, FullSpan, 1);
      while (vertex_backlog.size() < TargetVertices) begin
         if (!long_done && vertex_backlog.size() > 400) begin
            queue_polygon(MaxVertices, FullSpan, 0);
            queue_polygon(MaxVertices + 1, FullSpan, 0);
            queue_polygon(MaxVertices + 12, 64, 0);
            long_done = 1'b1;
         end
         drain = ($urandom_range(11, 0) == 0);
         pick  = $urandom_range(19, 0);
         if (pick < 10) begin
            queue_polygon($urandom_range(8, 3), FullSpan, drain);
         end else if (pick < 14) begin
            queue_polygon($urandom_range(12, 3), $urandom_range(1000, 1), drain);
         end else if (pick < 17) begin
            queue_polygon($urandom_range(6, 3), 2, drain);
         end else if (pick < 18) begin
            queue_polygon($urandom_range(2, 1), FullSpan, drain);
         end else begin
            queue_polygon($urandom_range(40, 9), FullSpan, drain);
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (vertex_backlog.size() != 0 || req_bus.valid) @(posedge clock);
      while (pending_centroids.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);

      if (mismatch_count == 0 && pending_centroids.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
